@@ hw/rtl/i2cm_pkg.sv @@
// Shared types, command codes and helpers for the I2C master bit engine.
// No dependencies; imported by i2cm_seq and i2c_master_bit_engine.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned TdataInW = 16;
  localparam int unsigned TdataOutW = 16;
  localparam int unsigned CmdW = 3;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgShortWait = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLongWait = 1'd1;

  localparam logic [DataW-1:0] ShortWaitRst = 8'd2;
  localparam logic [DataW-1:0] LongWaitRst = 8'd5;
  localparam logic [3:0] RecoveryClocks = 4'd9;

  typedef enum logic [CmdW-1:0] {
    CmdTick     = 3'd0,
    CmdStart    = 3'd1,
    CmdStop     = 3'd2,
    CmdWrite    = 3'd3,
    CmdRead     = 3'd4,
    CmdRecover  = 3'd5,
    CmdRsvd6    = 3'd6,
    CmdRsvd7    = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] data_byte;
    logic             ack_send;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             done_res;
    logic             busy_res;
    logic             sda_released;
    logic             sda_level;
    logic             scl_level;
  } result_t;

  // A wait register of zero still waits one tick.
  function automatic logic [DataW-1:0] wait_len(input logic [DataW-1:0] ticks);
    wait_len = (ticks == '0) ? DataW'(1) : ticks;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2cm_seq.sv @@
// Pin sequencer: phase state machine, counters, shift register and wait registers.
// Depends on i2cm_pkg. Advances once per item when step_i is high.
`default_nettype none

module i2cm_seq
  import i2cm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire item_t                item_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [DataW-1:0]     cfg_data_i,
  output result_t                   res_o
);

  localparam logic [4:0] PhIdle = 5'd0;
  localparam logic [4:0] PhSt0  = 5'd1;
  localparam logic [4:0] PhSt1  = 5'd2;
  localparam logic [4:0] PhSp0  = 5'd3;
  localparam logic [4:0] PhSp1  = 5'd4;
  localparam logic [4:0] PhWr0  = 5'd5;
  localparam logic [4:0] PhWrH  = 5'd6;
  localparam logic [4:0] PhWrL  = 5'd7;
  localparam logic [4:0] PhWrA  = 5'd8;
  localparam logic [4:0] PhWrB  = 5'd9;
  localparam logic [4:0] PhFin  = 5'd10;
  localparam logic [4:0] PhRd0  = 5'd11;
  localparam logic [4:0] PhRdH  = 5'd12;
  localparam logic [4:0] PhRdL  = 5'd13;
  localparam logic [4:0] PhRdA  = 5'd14;
  localparam logic [4:0] PhRdB  = 5'd15;
  localparam logic [4:0] PhRdC  = 5'd16;
  localparam logic [4:0] PhRdE  = 5'd17;
  localparam logic [4:0] PhRc0  = 5'd18;
  localparam logic [4:0] PhRc1  = 5'd19;
  localparam logic [4:0] PhRcA  = 5'd20;
  localparam logic [4:0] PhRcB  = 5'd21;
  localparam logic [4:0] PhRcC  = 5'd22;
  localparam logic [4:0] PhRcD  = 5'd23;
  localparam logic [4:0] PhRcE  = 5'd24;

  logic [4:0]       phase_q, phase_d;
  logic [3:0]       bit_cnt_q, bit_cnt_d;
  logic [DataW-1:0] shift_q, shift_d;
  logic [DataW-1:0] wait_q, wait_d;
  logic [3:0]       rep_q, rep_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             sda_rel_q, sda_rel_d;
  logic             ack_q, ack_d;
  logic [DataW-1:0] rd_byte_q, rd_byte_d;
  logic [DataW-1:0] short_q, long_q;
  logic             done;

  // Next state: optional command entry, then one group of pin changes
  always_comb begin
    logic             do_run;
    logic [4:0]       ph;
    logic [DataW-1:0] wait_dec;
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    wait_d    = wait_q;
    rep_d     = rep_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    sda_rel_d = sda_rel_q;
    ack_d     = ack_q;
    rd_byte_d = rd_byte_q;
    done      = 1'b0;
    do_run    = 1'b0;
    ph        = phase_q;
    wait_dec  = wait_q - DataW'(wait_q != '0);

    if (phase_q == PhIdle) begin
      do_run = 1'b1;
      unique case (cmd_e'(item_i.cmd))
        CmdStart:   ph = PhSt0;
        CmdStop:    ph = PhSp0;
        CmdWrite: begin
          ph        = PhWr0;
          shift_d   = item_i.data_byte;
          bit_cnt_d = '0;
        end
        CmdRead: begin
          ph    = PhRd0;
          ack_d = item_i.ack_send;
        end
        CmdRecover: ph = PhRc0;
        default:    do_run = 1'b0;
      endcase
    end else begin
      wait_d = wait_dec;
      do_run = (wait_dec == '0);
    end

    if (do_run) begin
      unique case (ph)
        PhSt0: begin
          sda_rel_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhSt1;
        end
        PhSt1: begin
          sda_d = 1'b0; scl_d = 1'b0; phase_d = PhIdle; done = 1'b1;
        end
        PhSp0: begin
          sda_rel_d = 1'b0; sda_d = 1'b0; scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhSp1;
        end
        PhSp1: begin
          sda_d = 1'b1; phase_d = PhIdle; done = 1'b1;
        end
        PhWr0: begin
          sda_rel_d = 1'b0;
          wait_d = wait_len(short_q); phase_d = PhWrH;
        end
        PhWrH: begin
          if (bit_cnt_q[3]) begin
            // all eight bits out: ACK clock with SDA released
            sda_rel_d = 1'b1; scl_d = 1'b1;
            wait_d = wait_len(short_q); phase_d = PhWrB;
          end else begin
            sda_d   = shift_q[DataW-1];
            shift_d = {shift_q[DataW-2:0], 1'b0};
            scl_d   = 1'b1;
            wait_d = wait_len(short_q); phase_d = PhWrL;
          end
        end
        PhWrL: begin
          scl_d = 1'b0; bit_cnt_d = bit_cnt_q + 4'd1;
          wait_d = wait_len(short_q); phase_d = PhWrH;
        end
        PhWrA: begin
          sda_rel_d = 1'b1; scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhWrB;
        end
        PhWrB: begin
          scl_d = 1'b0;
          wait_d = wait_len(short_q); phase_d = PhFin;
        end
        PhRd0: begin
          sda_rel_d = 1'b1; shift_d = '0; bit_cnt_d = '0;
          wait_d = wait_len(short_q); phase_d = PhRdH;
        end
        PhRdH: begin
          if (bit_cnt_q[3]) begin
            // byte complete: drive the chosen ack
            sda_rel_d = 1'b0; sda_d = ~ack_q;
            wait_d = wait_len(short_q); phase_d = PhRdB;
          end else begin
            scl_d = 1'b1;
            wait_d = wait_len(short_q); phase_d = PhRdL;
          end
        end
        PhRdL: begin
          shift_d   = {shift_q[DataW-2:0], item_i.sda_in};
          scl_d     = 1'b0;
          bit_cnt_d = bit_cnt_q + 4'd1;
          wait_d = wait_len(short_q); phase_d = PhRdH;
        end
        PhRdA: begin
          sda_rel_d = 1'b0; sda_d = ~ack_q;
          wait_d = wait_len(short_q); phase_d = PhRdB;
        end
        PhRdB: begin
          scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhRdC;
        end
        PhRdC: begin
          scl_d = 1'b0;
          wait_d = wait_len(short_q); phase_d = PhRdE;
        end
        PhRdE: begin
          sda_d = 1'b0; rd_byte_d = shift_q; phase_d = PhIdle; done = 1'b1;
        end
        PhRc0: begin
          sda_rel_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhRc1;
        end
        PhRc1: begin
          // SCL low with SDA held high, then straight into the first recovery clock
          scl_d = 1'b0; rep_d = '0; sda_d = 1'b1;
          wait_d = wait_len(long_q); phase_d = PhRcB;
        end
        PhRcA: begin
          if (rep_q >= RecoveryClocks) begin
            sda_rel_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
            wait_d = wait_len(short_q); phase_d = PhRcE;
          end else begin
            sda_d = 1'b1;
            wait_d = wait_len(long_q); phase_d = PhRcB;
          end
        end
        PhRcB: begin
          scl_d = 1'b1;
          wait_d = wait_len(long_q); phase_d = PhRcC;
        end
        PhRcC: begin
          scl_d = 1'b0; rep_d = rep_q + 4'd1;
          wait_d = wait_len(long_q); phase_d = PhRcA;
        end
        PhRcD: begin
          sda_rel_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhRcE;
        end
        PhRcE: begin
          // repeated start: SDA goes low while SCL stays high, ready for the stop
          sda_d = 1'b0; scl_d = 1'b1;
          wait_d = wait_len(short_q); phase_d = PhSp1;
        end
        default: begin
          phase_d = PhIdle; done = 1'b1;
        end
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      wait_q    <= '0;
      rep_q     <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      sda_rel_q <= 1'b0;
      ack_q     <= 1'b0;
      rd_byte_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      wait_q    <= wait_d;
      rep_q     <= rep_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      sda_rel_q <= sda_rel_d;
      ack_q     <= ack_d;
      rd_byte_q <= rd_byte_d;
    end
  end

  // Wait length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= ShortWaitRst;
      long_q  <= LongWaitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShortWait: short_q <= cfg_data_i;
        CfgLongWait:  long_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign res_o.scl_level    = scl_d;
  assign res_o.sda_level    = sda_d;
  assign res_o.sda_released = sda_rel_d;
  assign res_o.busy_res     = (phase_d != PhIdle);
  assign res_o.done_res     = done;
  assign res_o.read_data    = rd_byte_d;

endmodule

`default_nettype wire

@@ hw/rtl/i2c_master_bit_engine.sv @@
// I2C master bit engine top level: input beat register, sequencer, result register.
// Depends on i2cm_pkg and i2cm_seq.
//
// Each input beat (a command or a tick) yields exactly one output beat showing the
// SCL/SDA pin levels after that beat, busy/done flags and the last read byte. A beat
// is captured in an input register, the sequencer advances once on it when the output
// side can take it, and the result lands in an output register. One beat is accepted
// every cycle while the output side keeps up; the single sequencer state update per
// cycle sets that rate. Commands are honored only while idle, otherwise they count
// as ticks. Wait lengths must be written through the cfg port (index 0 short wait,
// index 1 long wait) only while no beat is outstanding; the block does not enforce it.
`default_nettype none

module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] data_byte, [8] ack_send, [9] sda_in, [15:10] zero
  input  wire logic [TdataInW-1:0]   s_axis_tdata,
  // [2:0] cmd
  input  wire logic [CmdW-1:0]       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_released, [3] busy_res, [4] done_res,
  // [12:5] read_data, [15:13] zero
  output logic [TdataOutW-1:0]       m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [DataW-1:0]      cfg_data_i
);

  logic    in_v_q;
  item_t   in_q;
  logic    out_v_q;
  result_t out_q;
  result_t res;
  logic    advance;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.cmd       <= s_axis_tuser;
      in_q.data_byte <= s_axis_tdata[7:0];
      in_q.ack_send  <= s_axis_tdata[8];
      in_q.sda_in    <= s_axis_tdata[9];
    end
  end

  i2cm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_q};

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_chk.sv @@
// Port-level checker for the I2C master bit engine, with its bind statement.
// Depends on i2c_master_bit_engine being compiled first.
`default_nettype none

module i2cm_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  // A finishing beat never reports busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done and busy in the same beat");

  // Input backpressure only comes from a stalled full output
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind i2c_master_bit_engine i2cm_chk u_i2cm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
